/* hw/rtl/cdiv_pkg.sv */
package cdiv_pkg;

    // Default operand width and quotient fraction bits
    localparam int unsigned CDIV_IN_WIDTH      = 16;
    localparam int unsigned CDIV_OUT_FRAC_BITS = 16;

    // Quotient word width and full-scale codes
    localparam int unsigned QUOT_W   = 32;
    localparam logic [QUOT_W-1:0] POS_FULL = {1'b0, {(QUOT_W-1){1'b1}}};
    localparam logic [QUOT_W-1:0] NEG_FULL = {1'b1, {(QUOT_W-1){1'b0}}};

endpackage

/* hw/rtl/complex_divide_top.sv */
// Channel  | Ports            | Transaction contents (lowest bits first)
// ---------+------------------+----------------------------------------------
// input    | s_axis_t*        | tdata: num_re, num_im, den_re, den_im
// result   | m_axis_t*        | tdata: quot_re, quot_im; tuser: zero_divisor, saturated
//
// One transaction enters per clock while the output register is not held;
// every input gives exactly one result. Pipeline: input register, product
// stage, sum stage, magnitude stage, one restoring-division stage per
// quotient bit (both parts side by side), and the output register.
// aresetn is synchronous and active low; it clears only the valid bits.
// When the output register is full and not taken, every stage holds.
module complex_divide_top
    import cdiv_pkg::*;
#(
    parameter int unsigned IN_WIDTH      = CDIV_IN_WIDTH,
    parameter int unsigned OUT_FRAC_BITS = CDIV_OUT_FRAC_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // num_re, num_im, den_re, den_im (IN_WIDTH each), zero padded to bytes
    input  logic [((4*IN_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // quot_re [31:0], quot_im [63:32]
    output logic [2*QUOT_W-1:0]          m_axis_tdata,
    // zero_divisor [0], saturated [1]
    output logic [1:0]                   m_axis_tuser
);

    localparam int unsigned W  = IN_WIDTH;
    localparam int unsigned MW = 2 * IN_WIDTH;          // magnitudes and divisor
    localparam int unsigned QB = MW + OUT_FRAC_BITS;    // quotient bits to develop

    typedef struct packed {
        logic [MW-1:0]     rem;
        logic [QB-1:0]     num;
        logic [QUOT_W:0]   q;
        logic              big;
        logic              neg;
    } lane_t;

    typedef struct packed {
        logic          vld;
        logic [MW-1:0] den;
        lane_t         re;
        lane_t         im;
    } dstage_t;

    // One restoring-division step: bring down a dividend bit, try subtract
    function automatic lane_t lane_step(lane_t a, logic [MW-1:0] d);
        lane_t       r;
        logic [MW:0] rem_sh;
        logic [MW:0] diff;
        logic        ge;
        rem_sh = {a.rem, a.num[QB-1]};
        diff   = rem_sh - {1'b0, d};
        ge     = (rem_sh >= {1'b0, d});
        r.rem  = ge ? diff[MW-1:0] : rem_sh[MW-1:0];
        r.num  = a.num << 1;
        r.q    = {a.q[QUOT_W-1:0], ge};
        r.big  = a.big | a.q[QUOT_W];
        r.neg  = a.neg;
        return r;
    endfunction

    // Signed saturation of a sign-magnitude quotient
    function automatic logic [QUOT_W:0] lane_out(lane_t a);
        logic [QUOT_W-1:0] v;
        logic              sat;
        if (a.neg) begin
            sat = a.big | a.q[QUOT_W] | (a.q[QUOT_W-1] & (|a.q[QUOT_W-2:0]));
            v   = sat ? NEG_FULL : (QUOT_W'(0) - a.q[QUOT_W-1:0]);
        end else begin
            sat = a.big | a.q[QUOT_W] | a.q[QUOT_W-1];
            v   = sat ? POS_FULL : a.q[QUOT_W-1:0];
        end
        return {sat, v};
    endfunction

    // Whole pipeline moves together unless a finished result is held
    logic adv;
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // Stage 1: operand register
    logic                v1_reg;
    logic signed [W-1:0] nr_reg, ni_reg, dr_reg, di_reg;

    // Stage 2: products
    logic                 v2_reg;
    logic signed [MW-1:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg, p_dr_reg, p_di_reg;

    // Stage 3: cross terms and squared magnitude
    logic               v3_reg;
    logic signed [MW:0] r_reg, j_reg, d_reg;

    // Stage 4 .. : division
    dstage_t dv_reg [QB+1];
    lane_t   re0, im0;
    logic [MW:0] r_abs, j_abs;

    always_comb begin
        r_abs     = r_reg[MW] ? ((MW+1)'(0) - r_reg) : r_reg;
        j_abs     = j_reg[MW] ? ((MW+1)'(0) - j_reg) : j_reg;
        re0.rem   = '0;
        re0.num   = {r_abs[MW-1:0], {OUT_FRAC_BITS{1'b0}}};
        re0.q     = '0;
        re0.big   = 1'b0;
        re0.neg   = r_reg[MW];
        im0.rem   = '0;
        im0.num   = {j_abs[MW-1:0], {OUT_FRAC_BITS{1'b0}}};
        im0.q     = '0;
        im0.big   = 1'b0;
        im0.neg   = j_reg[MW];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            dv_reg[0].vld <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            dv_reg[0].vld <= v3_reg;
        end
        if (adv) begin
            nr_reg   <= s_axis_tdata[W-1:0];
            ni_reg   <= s_axis_tdata[2*W-1:W];
            dr_reg   <= s_axis_tdata[3*W-1:2*W];
            di_reg   <= s_axis_tdata[4*W-1:3*W];
            p_rr_reg <= nr_reg * dr_reg;
            p_ii_reg <= ni_reg * di_reg;
            p_ir_reg <= ni_reg * dr_reg;
            p_ri_reg <= nr_reg * di_reg;
            p_dr_reg <= dr_reg * dr_reg;
            p_di_reg <= di_reg * di_reg;
            r_reg    <= p_rr_reg + p_ii_reg;
            j_reg    <= p_ir_reg - p_ri_reg;
            d_reg    <= p_dr_reg + p_di_reg;
            dv_reg[0].den <= d_reg[MW-1:0];
            dv_reg[0].re  <= re0;
            dv_reg[0].im  <= im0;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_div
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k+1].vld <= 1'b0;
            end else if (adv) begin
                dv_reg[k+1].vld <= dv_reg[k].vld;
            end
            if (adv) begin
                dv_reg[k+1].den <= dv_reg[k].den;
                dv_reg[k+1].re  <= lane_step(dv_reg[k].re, dv_reg[k].den);
                dv_reg[k+1].im  <= lane_step(dv_reg[k].im, dv_reg[k].den);
            end
        end
    end

    // Output stage: saturate, override on a zero divisor
    logic [QUOT_W:0] re_fin, im_fin;
    logic            zero_fin;
    logic [QUOT_W-1:0] qre_next, qim_next;
    logic [1:0]      user_next;

    always_comb begin
        re_fin   = lane_out(dv_reg[QB].re);
        im_fin   = lane_out(dv_reg[QB].im);
        zero_fin = (dv_reg[QB].den == '0);
        if (zero_fin) begin
            qre_next  = dv_reg[QB].re.neg ? NEG_FULL : POS_FULL;
            qim_next  = dv_reg[QB].im.neg ? NEG_FULL : POS_FULL;
            user_next = 2'b01;
        end else begin
            qre_next  = re_fin[QUOT_W-1:0];
            qim_next  = im_fin[QUOT_W-1:0];
            user_next = {re_fin[QUOT_W] | im_fin[QUOT_W], 1'b0};
        end
    end

    logic                  out_vld_reg;
    logic [2*QUOT_W-1:0]   out_data_reg;
    logic [1:0]            out_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= dv_reg[QB].vld;
        end
        if (adv) begin
            out_data_reg <= {qim_next, qre_next};
            out_user_reg <= user_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

// Complex divider regression: every operand set that is fed in is also run
// through a behavioral divider, and each result from the DUT is checked
// against the oldest prediction still waiting.
module testbench;
    import cdiv_pkg::*;

    localparam int unsigned LATENCY    = 2*CDIV_IN_WIDTH + CDIV_OUT_FRAC_BITS + 5;
    localparam int unsigned N_RANDOM   = 1700;
    localparam int unsigned WATCHDOG   = 3000;
    localparam int unsigned STALL_FROM = 2500;   // cycle where the long receiver stall starts
    localparam int unsigned STALL_LEN  = 400;

    typedef struct packed {
        logic signed [15:0] den_im;
        logic signed [15:0] den_re;
        logic signed [15:0] num_im;
        logic signed [15:0] num_re;
    } operands_t;

    typedef struct packed {
        logic        saturated;
        logic        zero_divisor;
        logic [31:0] quot_im;
        logic [31:0] quot_re;
    } quotient_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    operands_t pending_ops[$];     // operand sets waiting to be driven
    quotient_t expected_quots[$];  // predicted quotients in arrival order
    operands_t cur_ops;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned cycle_cnt = 0;
    int unsigned idle_cnt = 0;
    int unsigned n_sent = 0;
    int unsigned n_checked = 0;
    int unsigned n_errors = 0;
    int unsigned n_zero = 0;
    int unsigned n_sat = 0;
    logic        saw_backpressure = 1'b0;

    complex_divide_top DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #2 aclk = ~aclk;

    // Truncating Q16.16 division of the cross terms by |den|^2, saturated.
    function automatic logic [31:0] clip_quot(input longint cross_term, input longint mag2,
                                              inout logic sat);
        longint mag;
        longint q;
        mag = (cross_term < 0) ? -cross_term : cross_term;
        q = (mag <<< CDIV_OUT_FRAC_BITS) / mag2;
        if (cross_term < 0) begin
            if (q > 64'sh8000_0000) begin
                sat = 1'b1;
                return NEG_FULL;
            end
            return 32'(-q);
        end
        if (q > 64'sh7FFF_FFFF) begin
            sat = 1'b1;
            return POS_FULL;
        end
        return 32'(q);
    endfunction

    function automatic quotient_t divide_complex(input operands_t op);
        quotient_t res;
        longint re_cross;
        longint im_cross;
        longint mag2;
        logic sat;
        re_cross = longint'(op.num_re) * op.den_re + longint'(op.num_im) * op.den_im;
        im_cross = longint'(op.num_im) * op.den_re - longint'(op.num_re) * op.den_im;
        mag2 = longint'(op.den_re) * op.den_re + longint'(op.den_im) * op.den_im;
        sat = 1'b0;
        if (mag2 == 0) begin
            // both cross terms are zero here, so both parts go positive full scale
            res.quot_re = (re_cross < 0) ? NEG_FULL : POS_FULL;
            res.quot_im = (im_cross < 0) ? NEG_FULL : POS_FULL;
            res.zero_divisor = 1'b1;
            res.saturated = 1'b0;
        end else begin
            res.quot_re = clip_quot(re_cross, mag2, sat);
            res.quot_im = clip_quot(im_cross, mag2, sat);
            res.zero_divisor = 1'b0;
            res.saturated = sat;
        end
        return res;
    endfunction

    function automatic logic [15:0] rand_part(input int unsigned kind);
        case (kind)
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($signed($urandom_range(0, 128)) - 64);
            default: begin
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    3: return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
        endcase
    endfunction

    // Driver: hold the transaction until accepted, then advance in bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_quots.push_back(divide_complex(cur_ops));
                n_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    cur_ops = pending_ops.pop_front();
                    s_axis_tdata <= cur_ops;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left == 0) begin
                        // about one burst in four, at random, is long; each new burst also draws a random gap
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 12);
                        gap_left = $urandom_range(0, 5);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall on its own random pattern, plus one long hold-off window.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= STALL_FROM && cycle_cnt < STALL_FROM + STALL_LEN)
            m_axis_tready <= 1'b0;
        else if (cycle_cnt[9])
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 2) != 0);
        if (s_axis_tvalid && !s_axis_tready)
            saw_backpressure <= 1'b1;
    end

    // Monitor: compare each result transaction with the oldest prediction.
    always @(posedge aclk) begin
        quotient_t got;
        quotient_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata};
            if (expected_quots.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: unexpected result re=%h im=%h user=%b",
                             got.quot_re, got.quot_im, m_axis_tuser);
            end else begin
                want = expected_quots.pop_front();
                n_checked++;
                n_zero += want.zero_divisor;
                n_sat += want.saturated;
                if (got !== want) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: result %0d exp re=%h im=%h zd=%b sat=%b got re=%h im=%h zd=%b sat=%b",
                                 n_checked, want.quot_re, want.quot_im, want.zero_divisor,
                                 want.saturated, got.quot_re, got.quot_im,
                                 got.zero_divisor, got.saturated);
                end
            end
        end
    end

    // Watchdog: count cycles in which neither side moves a transaction.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG) begin
            $display("Timeout with %0d results outstanding", expected_quots.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_ops(input logic [15:0] nr, input logic [15:0] ni,
                            input logic [15:0] dr, input logic [15:0] di);
        operands_t op;
        op.num_re = nr;
        op.num_im = ni;
        op.den_re = dr;
        op.den_im = di;
        pending_ops.push_back(op);
    endtask

    task automatic wait_drained;
        while (pending_ops.size() > 0 || s_axis_tvalid || expected_quots.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        int unsigned kind;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, zero divisor, saturation, tiny negative quotients.
        push_ops(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        push_ops(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        push_ops(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        push_ops(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        push_ops(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        push_ops(16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
        push_ops(16'h8000, 16'h8000, 16'h0000, 16'h0000);
        push_ops(16'h7FFF, 16'h7FFF, 16'h0001, 16'h0000);
        push_ops(16'h8000, 16'h7FFF, 16'h0001, 16'h0000);
        push_ops(16'h8000, 16'h8000, 16'h0000, 16'hFFFF);
        push_ops(16'h7FFF, 16'h0000, 16'h0000, 16'h0001);
        push_ops(16'hFFFF, 16'h0000, 16'h7FFF, 16'h0000);
        push_ops(16'h0000, 16'hFFFF, 16'h7FFF, 16'h0000);
        push_ops(16'h0001, 16'h0001, 16'h8000, 16'h8000);
        push_ops(16'h0000, 16'h0000, 16'h1234, 16'hABCD);
        push_ops(16'h4000, 16'h0000, 16'h4000, 16'h0000);
        push_ops(16'h0100, 16'h0000, 16'h0080, 16'h0000);
        push_ops(16'h0100, 16'h0000, 16'h007F, 16'h0000);
        push_ops(16'hFF00, 16'h0000, 16'h0080, 16'h0000);
        push_ops(16'h2000, 16'hE000, 16'h0010, 16'hFFF0);

        // Let the pipeline drain completely before the random phase.
        wait_drained;
        repeat (LATENCY) @(posedge aclk);

        for (int i = 0; i < N_RANDOM; i++) begin
            kind = $urandom_range(0, 19);
            if (kind == 0)
                push_ops(rand_part(0), rand_part(0), 16'h0000, 16'h0000);
            else if (kind < 5)
                push_ops(rand_part(0), rand_part(0), rand_part(1), rand_part(1));
            else if (kind < 8)
                push_ops(rand_part(2), rand_part(2), rand_part(2), rand_part(2));
            else
                push_ops(rand_part(0), rand_part(0), rand_part(0), rand_part(0));
        end

        wait_drained;
        repeat (2 * LATENCY) @(posedge aclk);

        $display("Checked %0d results (%0d zero divisor, %0d saturated); input stall seen: %0b",
                 n_checked, n_zero, n_sat, saw_backpressure);
        $display("Extremes, zero divisors, clipping and bursty traffic with a long output stall");
        if (n_errors == 0 && expected_quots.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", n_errors, expected_quots.size());
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
